>>> hw/rtl/tms_pkg.sv
// tms_pkg: shared constants, codes and types of the turing machine stepper
// no dependencies; imported by every other file of the block

package tms_pkg;

    localparam int TAPE_CELLS_DEF = 32768;
    localparam int STATES_DEF     = 8;

    // tape memory row geometry
    localparam int ROW_BITS = 32;
    localparam int ROW_LOG  = 5;

    // rule registers
    localparam int NUM_RULES  = 8;
    localparam int RULE_W     = 12;
    localparam int RULE_IDX_W = 3;

    // apb port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // beat field widths
    localparam int BUDGET_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int STEPS_W    = 32;
    localparam int HEAD_POS_W = 15;
    localparam int MSTATE_W   = 3;
    localparam int ONES_W     = 16;

    localparam logic [3:0] HALT_CODE = 4'd8;

    localparam logic [STATUS_W-1:0] ST_RUN      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HALT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TAPE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADSTATE = 2'd3;

    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_RUN     = 1'b1;

    typedef struct packed {
        logic                wbit;
        logic                ones_up;
        logic                ones_dn;
        logic                move_ok;
        logic                take_next;
        logic                count;
        logic [MSTATE_W-1:0] next_state;
        logic [STATUS_W-1:0] status;
    } t_step_ctl;

endpackage

>>> hw/rtl/tms_if.sv
// tms_if: valid/ready channel interfaces for command beats and result beats
// depends on tms_pkg

interface tms_in_if;
    import tms_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd;
    logic [BUDGET_W-1:0] step_budget;

    modport source(output valid, cmd, step_budget, input ready);
    modport sink(input valid, cmd, step_budget, output ready);
endinterface

interface tms_out_if;
    import tms_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [STEPS_W-1:0]    steps_done;
    logic [HEAD_POS_W-1:0] head_pos;
    logic [MSTATE_W-1:0]   machine_state;
    logic [ONES_W-1:0]     ones_count;

    modport source(output valid, status, steps_done, head_pos, machine_state, ones_count,
                   input ready);
    modport sink(input valid, status, steps_done, head_pos, machine_state, ones_count,
                 output ready);
endinterface

>>> hw/rtl/tms_cfg_regs.sv
// tms_cfg_regs: apb rule registers with a registered rule fetch port
// depends on tms_pkg

module tms_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tms_pkg::APB_AW-1:0]       paddr,
    input  logic [tms_pkg::APB_DW-1:0]       pwdata,
    output logic [tms_pkg::APB_DW-1:0]       prdata,
    output logic                             pready,
    input  logic                             i_rule_re,
    input  logic [tms_pkg::RULE_IDX_W-1:0]   i_rule_sel,
    output logic [tms_pkg::RULE_W-1:0]       o_rule
);
    import tms_pkg::*;

    logic [RULE_W-1:0]     r_rules [NUM_RULES];
    logic [APB_DW-1:0]     r_prdata;
    logic [RULE_W-1:0]     r_rule;
    logic [RULE_IDX_W-1:0] w_idx;

    assign w_idx  = paddr[APB_AW-1:2];
    assign pready = 1'b1;
    assign prdata = r_prdata;
    assign o_rule = r_rule;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_RULES; i++) begin
                r_rules[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            r_rules[w_idx] <= pwdata[RULE_W-1:0];
        end
    end

    // read data captured in the setup cycle
    always_ff @(posedge i_clk) begin
        if (psel && !penable) begin
            r_prdata <= APB_DW'(r_rules[w_idx]);
        end
        if (i_rule_re) begin
            r_rule <= r_rules[i_rule_sel];
        end
    end

endmodule

>>> hw/rtl/tms_tape_mem.sv
// tms_tape_mem: tape storage, one write port and one registered read port
// depends on tms_pkg

module tms_tape_mem #(
    parameter int ROWS = 1024,
    parameter int RAW  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [RAW-1:0]                i_waddr,
    input  logic [tms_pkg::ROW_BITS-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [RAW-1:0]                i_raddr,
    output logic [tms_pkg::ROW_BITS-1:0]  o_rdata
);
    import tms_pkg::*;

    logic [ROW_BITS-1:0] r_mem [ROWS];
    logic [ROW_BITS-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> hw/rtl/tms_step_unit.sv
// tms_step_unit: decodes one transition from the rule word and the read symbol
// depends on tms_pkg

module tms_step_unit #(
    parameter int TAPE_CELLS = 32768,
    parameter int STATES     = 8,
    parameter int HW         = 15
) (
    input  logic [HW-1:0]               i_head,
    input  logic                        i_sym,
    input  logic [tms_pkg::RULE_W-1:0]  i_rule,
    output tms_pkg::t_step_ctl          o_ctl,
    output logic [HW-1:0]               o_head_next
);
    import tms_pkg::*;

    logic [5:0] w_rule;
    logic       w_right;
    logic [3:0] w_next;
    logic       w_edge;

    assign w_rule  = i_sym ? i_rule[11:6] : i_rule[5:0];
    assign w_right = w_rule[1];
    assign w_next  = w_rule[5:2];
    assign w_edge  = w_right ? (i_head == HW'(TAPE_CELLS - 1)) : (i_head == '0);

    assign o_head_next = w_right ? i_head + HW'(1) : i_head - HW'(1);

    always_comb begin
        o_ctl            = '0;
        o_ctl.wbit       = w_rule[0];
        o_ctl.ones_up    = w_rule[0] & ~i_sym;
        o_ctl.ones_dn    = ~w_rule[0] & i_sym;
        o_ctl.next_state = w_next[MSTATE_W-1:0];
        o_ctl.status     = ST_RUN;
        if (w_edge) begin
            o_ctl.status = ST_TAPE;
        end else begin
            o_ctl.move_ok = 1'b1;
            if (w_next == HALT_CODE) begin
                o_ctl.status = ST_HALT;
                o_ctl.count  = 1'b1;
            end else if (32'(w_next) >= STATES) begin
                o_ctl.status = ST_BADSTATE;
            end else begin
                o_ctl.take_next = 1'b1;
                o_ctl.count     = 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/turing_machine_stepper_top.sv
// Two-symbol turing machine stepper. A restart beat clears the tape by sweeping
// the tape memory one 32-cell row per cycle, ceil(TAPE_CELLS/32) rows (1024 by
// default), then returns its result; the same sweep runs once after reset, with
// the command channel not ready. A run beat executes each transition as a tape
// row read in S_READ, then rule decode and row write-back through the step unit
// in S_EXEC; a stalled result sits in the output register while the next
// command is taken.
// depends on tms_pkg, tms_if, tms_cfg_regs, tms_tape_mem, tms_step_unit

module turing_machine_stepper_top #(
    parameter int TAPE_CELLS = tms_pkg::TAPE_CELLS_DEF,
    parameter int STATES     = tms_pkg::STATES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tms_in_if.sink                      i_in,
    tms_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tms_pkg::APB_AW-1:0]  paddr,
    input  logic [tms_pkg::APB_DW-1:0]  pwdata,
    output logic [tms_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import tms_pkg::*;

    localparam int HW   = $clog2(TAPE_CELLS);
    localparam int ROWS = (TAPE_CELLS + ROW_BITS - 1) / ROW_BITS;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int OW   = $clog2(TAPE_CELLS + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [RAW-1:0]      r_row, n_row;
    logic                r_post, n_post;
    logic [HW-1:0]       r_head, n_head;
    logic [MSTATE_W-1:0] r_mstate, n_mstate;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [STEPS_W-1:0]  r_steps, n_steps;
    logic [OW-1:0]       r_ones, n_ones;
    logic [BUDGET_W-1:0] r_budget, n_budget;
    logic                r_ovalid, n_ovalid;

    logic [STATUS_W-1:0]   r_o_status;
    logic [STEPS_W-1:0]    r_o_steps;
    logic [HEAD_POS_W-1:0] r_o_head;
    logic [MSTATE_W-1:0]   r_o_mstate;
    logic [ONES_W-1:0]     r_o_ones;

    logic                in_acc;
    logic                w_load;
    logic [RULE_W-1:0]   w_rule;
    logic [ROW_BITS-1:0] w_rdata;
    logic [ROW_BITS-1:0] w_row_new;
    logic [ROW_LOG-1:0]  w_bit;
    logic [RAW-1:0]      w_head_row;
    logic                w_we;
    logic [RAW-1:0]      w_waddr;
    logic [ROW_BITS-1:0] w_wdata;
    t_step_ctl           w_ctl;
    logic [HW-1:0]       w_head_next;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_bit      = ROW_LOG'(r_head);
    assign w_head_row = RAW'(r_head >> ROW_LOG);
    assign w_load     = (r_state == S_DONE) && (!r_ovalid || o_out.ready);

    tms_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_rule_re  (r_state == S_READ),
        .i_rule_sel (r_mstate),
        .o_rule     (w_rule)
    );

    tms_tape_mem #(
        .ROWS (ROWS),
        .RAW  (RAW)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (r_state == S_READ),
        .i_raddr (w_head_row),
        .o_rdata (w_rdata)
    );

    tms_step_unit #(
        .TAPE_CELLS (TAPE_CELLS),
        .STATES     (STATES),
        .HW         (HW)
    ) u_step (
        .i_head      (r_head),
        .i_sym       (w_rdata[w_bit]),
        .i_rule      (w_rule),
        .o_ctl       (w_ctl),
        .o_head_next (w_head_next)
    );

    always_comb begin
        w_row_new        = w_rdata;
        w_row_new[w_bit] = w_ctl.wbit;
    end

    assign w_we    = (r_state == S_CLEAR) || (r_state == S_EXEC);
    assign w_waddr = (r_state == S_CLEAR) ? r_row : w_head_row;
    assign w_wdata = (r_state == S_CLEAR) ? '0 : w_row_new;

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_post   = r_post;
        n_head   = r_head;
        n_mstate = r_mstate;
        n_status = r_status;
        n_steps  = r_steps;
        n_ones   = r_ones;
        n_budget = r_budget;
        n_ovalid = r_ovalid;
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                n_row = r_row + RAW'(1);
                if (r_row == RAW'(ROWS - 1)) begin
                    n_state = r_post ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.cmd == CMD_RESTART) begin
                        n_head   = HW'(TAPE_CELLS / 2);
                        n_mstate = '0;
                        n_status = ST_RUN;
                        n_steps  = '0;
                        n_ones   = '0;
                        n_row    = '0;
                        n_post   = 1'b1;
                        n_state  = S_CLEAR;
                    end else begin
                        n_budget = i_in.step_budget;
                        if (i_in.step_budget == '0 || r_status != ST_RUN) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_ctl.move_ok) begin
                    n_head = w_head_next;
                end
                if (w_ctl.take_next) begin
                    n_mstate = w_ctl.next_state;
                end
                n_status = w_ctl.status;
                if (w_ctl.count && r_steps != '1) begin
                    n_steps = r_steps + STEPS_W'(1);
                end
                if (w_ctl.ones_up) begin
                    n_ones = r_ones + OW'(1);
                end else if (w_ctl.ones_dn) begin
                    n_ones = r_ones - OW'(1);
                end
                n_budget = r_budget - BUDGET_W'(1);
                if (w_ctl.status != ST_RUN || r_budget == BUDGET_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_row    <= '0;
            r_post   <= 1'b0;
            r_head   <= HW'(TAPE_CELLS / 2);
            r_mstate <= '0;
            r_status <= ST_RUN;
            r_steps  <= '0;
            r_ones   <= '0;
            r_budget <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_post   <= n_post;
            r_head   <= n_head;
            r_mstate <= n_mstate;
            r_status <= n_status;
            r_steps  <= n_steps;
            r_ones   <= n_ones;
            r_budget <= n_budget;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status <= r_status;
            r_o_steps  <= r_steps;
            r_o_head   <= HEAD_POS_W'(r_head);
            r_o_mstate <= r_mstate;
            r_o_ones   <= (32'(r_ones) > 32'hFFFF) ? '1 : ONES_W'(r_ones);
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.status        = r_o_status;
    assign o_out.steps_done    = r_o_steps;
    assign o_out.head_pos      = r_o_head;
    assign o_out.machine_state = r_o_mstate;
    assign o_out.ones_count    = r_o_ones;

endmodule

>>> hw/rtl/tms_checker.sv
// tms_checker: port-level assertions on the stepper, bound to the top level
// depends on tms_pkg and turing_machine_stepper_top

module tms_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_in_cmd,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [tms_pkg::STATUS_W-1:0]     i_out_status,
    input logic [tms_pkg::STEPS_W-1:0]      i_out_steps,
    input logic [tms_pkg::HEAD_POS_W-1:0]   i_out_head,
    input logic [tms_pkg::MSTATE_W-1:0]     i_out_mstate,
    input logic [tms_pkg::ONES_W-1:0]       i_out_ones
);
    import tms_pkg::*;

    logic                in_acc;
    logic                out_acc;
    logic                r_cmd_q [2];
    logic [1:0]          r_cnt;
    logic [STATUS_W-1:0] r_last_status;
    logic [STEPS_W-1:0]  r_last_steps;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // commands still owed a result beat, oldest first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_last_status <= ST_RUN;
            r_last_steps  <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10: begin
                    r_cmd_q[r_cnt[0]] <= i_in_cmd;
                    r_cnt             <= r_cnt + 2'd1;
                end
                2'b01: begin
                    r_cmd_q[0] <= r_cmd_q[1];
                    r_cnt      <= r_cnt - 2'd1;
                end
                2'b11: begin
                    if (r_cnt == 2'd1) begin
                        r_cmd_q[0] <= i_in_cmd;
                    end else begin
                        r_cmd_q[0] <= r_cmd_q[1];
                        r_cmd_q[1] <= i_in_cmd;
                    end
                end
                default: begin
                end
            endcase
            if (out_acc) begin
                r_last_status <= i_out_status;
                r_last_steps  <= i_out_steps;
            end
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("command channel stayed ready after a beat");

    a_restart_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_cmd_q[0] == CMD_RESTART |->
            i_out_status == ST_RUN && i_out_steps == '0 && i_out_ones == '0
            && i_out_mstate == '0)
        else $error("restart result not clean");

    a_sticky_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_cmd_q[0] == CMD_RUN && r_last_status != ST_RUN |->
            i_out_status == r_last_status && i_out_steps == r_last_steps)
        else $error("run advanced a stopped machine");

    a_steps_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_cmd_q[0] == CMD_RUN |-> i_out_steps >= r_last_steps)
        else $error("step count went backwards");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_out_status, i_out_steps, i_out_head, i_out_mstate, i_out_ones}))
        else $error("result beat changed while stalled");

endmodule

bind turing_machine_stepper_top tms_checker u_tms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_cmd     (i_in.cmd),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_steps  (o_out.steps_done),
    .i_out_head   (o_out.head_pos),
    .i_out_mstate (o_out.machine_state),
    .i_out_ones   (o_out.ones_count)
);
